FILE: sv/sorted_interval_timeline_macros.svh
// Assertion macros shared by the checker.
`ifndef SORTED_INTERVAL_TIMELINE_MACROS_SVH
`define SORTED_INTERVAL_TIMELINE_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define SIT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted_interval_timeline check failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define SIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_interval_timeline check failed");
`endif

FILE: sv/sit_pkg.sv
package sit_pkg;

  // Status codes of a result.
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_ORDER    = 2'd2;

  // Controller states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_SRCH,
    S_SRCH_WAIT,
    S_SRCH_CMP,
    S_DECIDE,
    S_INS_START,
    S_NB_RD0,
    S_NB_RD1,
    S_NB_WAIT,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_WR,
    S_MARK_RD,
    S_MARK_WR,
    S_RESULT
  } sit_state_t;

  // Datapath operations chosen by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SRCH_INIT,
    OP_SRCH_RD,
    OP_SRCH_STEP,
    OP_EMPTY_WR,
    OP_NB_RD0,
    OP_NB_RD1,
    OP_SHIFT_RD,
    OP_SHIFT_WR,
    OP_INS_WR,
    OP_MARK_RD,
    OP_MARK_WR,
    OP_RESULT
  } sit_op_t;

  // Commands from controller to datapath.
  typedef struct packed {
    sit_op_t    op;
    logic       srch_end;    // searching the end boundary
    logic       srch_from_p; // end search starts at start position
    logic       ins_end;     // inserting the end boundary
    logic       empty_second; // second write on an empty table
    logic [1:0] status;
  } sit_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic order_bad;
    logic empty;
    logic equal;
    logic srch_done;
    logic found;
    logic fits;
    logic start_found;
    logic end_found;
    logic has_nb;      // insert position has two neighbours
    logic shift_done;
    logic mark_done;
  } sit_stat_t;

endpackage

FILE: sv/sit_ram.sv
module sit_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/sit_datapath.sv
module sit_datapath #(
  parameter int MaxEntries  = 256,
  parameter int MaxCommands = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sit_pkg::sit_cmd_t  cmd,
  output sit_pkg::sit_stat_t stat,
  input  logic [5:0]         in_command_id,
  input  logic signed [31:0] in_start_time,
  input  logic signed [31:0] in_end_time,
  output logic [1:0]         res_status,
  output logic [8:0]         res_entry_count
);
  import sit_pkg::*;

  localparam int AW = $clog2(MaxEntries);
  localparam int CW = $clog2(MaxEntries + 1);

  // Request registers.
  logic [5:0]         cid_r;
  logic signed [31:0] s_r, e_r;
  logic [CW-1:0]      used_r, used_nxt;
  // Search state.
  logic [CW-1:0]      lo_r, hi_r, mid_r, p_r, q_r, pos_r, idx_r;
  logic               sf_r, ef_r, found_r;
  logic [63:0]        nb_r, m_r;

  // Memory ports.
  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [31:0]        wt, rt;
  logic [63:0]        wm, rm;
  logic [CW-1:0]      raddr_w;

  logic [63:0] bit_w;
  assign bit_w = ({1'b0, cid_r} < 7'(MaxCommands)) ? (64'd1 << cid_r) : 64'd0;

  logic [CW-1:0] mid_w;
  assign mid_w = lo_r + ((hi_r - lo_r) >> 1);

  logic [1:0] need_w;
  assign need_w = {1'b0, !sf_r} + {1'b0, (s_r != e_r) && !ef_r};

  sit_ram #(.Width(32), .Depth(MaxEntries)) u_time (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wt), .raddr(raddr), .rdata(rt));
  sit_ram #(.Width(64), .Depth(MaxEntries)) u_mask (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wm), .raddr(raddr), .rdata(rm));

  // Read address by operation.
  always_comb begin
    raddr_w = '0;
    unique case (cmd.op)
      OP_SRCH_RD:  raddr_w = mid_w;
      OP_NB_RD0:   raddr_w = pos_r - CW'(1);
      OP_NB_RD1:   raddr_w = pos_r;
      OP_SHIFT_RD: raddr_w = idx_r - CW'(1);
      OP_MARK_RD:  raddr_w = idx_r;
      default:     raddr_w = '0;
    endcase
  end
  assign raddr = raddr_w[AW-1:0];

  // Write port.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wt    = '0;
    wm    = '0;
    unique case (cmd.op)
      OP_EMPTY_WR: begin
        we    = 1'b1;
        waddr = cmd.empty_second ? AW'(1) : '0;
        wt    = cmd.empty_second ? e_r : s_r;
        wm    = bit_w;
      end
      OP_SHIFT_WR: begin
        we    = 1'b1;
        waddr = idx_r[AW-1:0];
        wt    = rt;
        wm    = rm;
      end
      OP_INS_WR: begin
        we    = 1'b1;
        waddr = pos_r[AW-1:0];
        wt    = cmd.ins_end ? e_r : s_r;
        wm    = nb_r;
      end
      OP_MARK_WR: begin
        we    = 1'b1;
        waddr = idx_r[AW-1:0];
        wt    = rt;
        wm    = rm | bit_w;
      end
      default: we = 1'b0;
    endcase
  end

  // Entry count.
  always_comb begin
    used_nxt = used_r;
    if (cmd.op == OP_EMPTY_WR) begin
      used_nxt = cmd.empty_second ? CW'(2) : CW'(1);
    end else if (cmd.op == OP_INS_WR) begin
      used_nxt = used_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        cid_r <= in_command_id;
        s_r   <= in_start_time;
        e_r   <= in_end_time;
        sf_r  <= 1'b0;
        ef_r  <= 1'b0;
      end
      OP_SRCH_INIT: begin
        lo_r    <= cmd.srch_from_p ? p_r : '0;
        hi_r    <= used_r;
        found_r <= 1'b0;
      end
      OP_SRCH_RD: mid_r <= mid_w;
      OP_SRCH_STEP: begin
        if ($signed(rt) == (cmd.srch_end ? e_r : s_r)) begin
          found_r <= 1'b1;
          lo_r    <= mid_r;
          hi_r    <= mid_r;
        end else if ($signed(rt) > (cmd.srch_end ? e_r : s_r)) begin
          hi_r <= mid_r;
        end else begin
          lo_r <= mid_r + CW'(1);
        end
      end
      OP_NB_RD0: begin
        nb_r <= '0;
        pos_r <= cmd.ins_end ? q_r : p_r;
        idx_r <= used_r;
      end
      OP_NB_RD1: m_r <= rm;
      OP_SHIFT_WR: idx_r <= idx_r - CW'(1);
      OP_INS_WR: idx_r <= p_r;
      OP_MARK_WR: idx_r <= idx_r + CW'(1);
      default: ;
    endcase
    // Capture the search outcome and the neighbour AND.
    if (cmd.op == OP_SHIFT_RD && idx_r == used_r && pos_r != '0 && pos_r < used_r) begin
      nb_r <= m_r & rm;
    end
    if (cmd.op == OP_SRCH_STEP && cmd.srch_end) begin
      q_r  <= ($signed(rt) == e_r) ? mid_r : q_r;
    end
    if (cmd.op == OP_NONE && stat.srch_done) begin
      if (cmd.srch_end) begin
        ef_r <= found_r;
        q_r  <= lo_r;
      end else begin
        sf_r  <= found_r;
        p_r   <= lo_r;
        // Marking starts at the start entry unless an insert moves it.
        idx_r <= lo_r;
      end
    end
  end

  assign stat.order_bad   = e_r < s_r;
  assign stat.empty       = used_r == '0;
  assign stat.equal       = s_r == e_r;
  assign stat.srch_done   = found_r || !(lo_r < hi_r);
  assign stat.found       = found_r;
  assign stat.fits        = ({1'b0, used_r} + (CW+1)'(need_w)) <= (CW+1)'(MaxEntries);
  assign stat.start_found = sf_r;
  assign stat.end_found   = ef_r;
  assign stat.has_nb      = pos_r != '0 && pos_r < used_r;
  assign stat.shift_done  = idx_r <= pos_r;
  assign stat.mark_done   = idx_r > q_r || idx_r >= used_r;

  assign res_status      = cmd.status;
  assign res_entry_count = 9'(used_r);

endmodule

FILE: sv/sit_ctrl.sv
module sit_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  sit_pkg::sit_stat_t stat,
  output sit_pkg::sit_cmd_t  cmd,
  output logic               res_load
);
  import sit_pkg::*;

  sit_state_t state_r, state_nxt;
  logic       srch_end_r, srch_end_nxt;  // which boundary is searched
  logic       ins_end_r, ins_end_nxt;    // which boundary is inserted
  logic       scnd_r, scnd_nxt;          // second empty-table write
  logic [1:0] st_r, st_nxt;
  logic       ov_r, ov_nxt;              // result waiting in output register
  logic       after_p_r, after_p_nxt;    // end search starts at start position

  // Next state.
  always_comb begin
    state_nxt    = state_r;
    srch_end_nxt = srch_end_r;
    ins_end_nxt  = ins_end_r;
    scnd_nxt     = scnd_r;
    st_nxt       = st_r;
    unique case (state_r)
      S_IDLE: if (in_valid && !ov_r) state_nxt = S_CHECK;
      S_CHECK: begin
        scnd_nxt    = 1'b0;
        ins_end_nxt = 1'b0;
        st_nxt      = ST_INSERTED;
        if (stat.order_bad) begin
          st_nxt = ST_ORDER;
          state_nxt = S_RESULT;
        end else if (stat.empty) begin
          state_nxt = S_INS_START;
        end else begin
          srch_end_nxt = 1'b0;
          state_nxt    = S_SRCH;
        end
      end
      S_SRCH: state_nxt = S_SRCH_WAIT;
      S_SRCH_WAIT: begin
        if (stat.srch_done) begin
          if (!srch_end_r) begin
            srch_end_nxt = 1'b1;
            state_nxt    = S_SRCH;
          end else begin
            state_nxt = S_DECIDE;
          end
        end else begin
          state_nxt = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: state_nxt = S_SRCH_WAIT;
      S_DECIDE: begin
        if (!stat.fits) begin
          st_nxt    = ST_FULL;
          state_nxt = S_RESULT;
        end else if (!stat.start_found) begin
          ins_end_nxt = 1'b0;
          state_nxt   = S_NB_RD0;
        end else if (stat.equal) begin
          state_nxt = S_MARK_RD;
        end else begin
          state_nxt = S_INS_START; // end re-search from start position
        end
      end
      S_INS_START: begin
        if (stat.empty || scnd_r) begin
          // Empty table writes.
          if (!scnd_r && !stat.equal) begin
            scnd_nxt = 1'b1;
          end else begin
            state_nxt = S_RESULT;
          end
        end else begin
          srch_end_nxt = 1'b1;
          state_nxt    = S_SRCH;
        end
      end
      S_NB_RD0: state_nxt = S_NB_RD1;
      S_NB_RD1: state_nxt = S_NB_WAIT;
      S_NB_WAIT: state_nxt = S_SHIFT_RD;
      S_SHIFT_RD: state_nxt = stat.shift_done ? S_INS_WR : S_SHIFT_WR;
      S_SHIFT_WR: state_nxt = S_SHIFT_RD;
      S_INS_WR: begin
        if (!ins_end_r && !stat.equal) begin
          srch_end_nxt = 1'b1;
          state_nxt    = S_SRCH;
        end else begin
          state_nxt = S_MARK_RD;
        end
      end
      S_MARK_RD: state_nxt = stat.mark_done ? S_RESULT : S_MARK_WR;
      S_MARK_WR: state_nxt = S_MARK_RD;
      S_RESULT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    // The end re-search from the start position ends in insert or marking.
    if (state_r == S_SRCH_WAIT && stat.srch_done && srch_end_r && ins_end_r == 1'b0
        && after_p_r) begin
      state_nxt = stat.found ? S_MARK_RD : S_NB_RD0;
      ins_end_nxt = 1'b1;
    end
  end

  // Second search pass from the start position.
  always_comb begin
    after_p_nxt = after_p_r;
    if (state_r == S_CHECK) after_p_nxt = 1'b0;
    else if (state_r == S_DECIDE || state_r == S_INS_WR) after_p_nxt = 1'b1;
  end

  // Commands.
  always_comb begin
    cmd              = '0;
    cmd.op           = OP_NONE;
    cmd.srch_end     = srch_end_r;
    cmd.srch_from_p  = after_p_r;
    cmd.ins_end      = ins_end_r;
    cmd.empty_second = scnd_r;
    cmd.status       = st_r;
    res_load         = 1'b0;
    unique case (state_r)
      S_IDLE:      if (in_valid && !ov_r) cmd.op = OP_LOAD;
      S_SRCH:      cmd.op = OP_SRCH_INIT;
      S_SRCH_WAIT: if (!stat.srch_done) cmd.op = OP_SRCH_RD;
      S_SRCH_CMP:  cmd.op = OP_SRCH_STEP;
      S_INS_START: if (stat.empty || scnd_r) cmd.op = OP_EMPTY_WR;
      S_NB_RD0:    cmd.op = OP_NB_RD0;
      S_NB_RD1:    cmd.op = OP_NB_RD0;
      S_NB_WAIT:   cmd.op = OP_NB_RD1;
      S_SHIFT_RD:  if (!stat.shift_done) cmd.op = OP_SHIFT_RD;
      S_SHIFT_WR:  cmd.op = OP_SHIFT_WR;
      S_INS_WR:    cmd.op = OP_INS_WR;
      S_MARK_RD:   if (!stat.mark_done) cmd.op = OP_MARK_RD;
      S_MARK_WR:   cmd.op = OP_MARK_WR;
      S_RESULT: begin
        cmd.op   = OP_RESULT;
        res_load = 1'b1;
      end
      default: cmd.op = OP_NONE;
    endcase
  end

  // Output register occupancy.
  always_comb begin
    ov_nxt = ov_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    if (res_load) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      srch_end_r <= 1'b0;
      ins_end_r  <= 1'b0;
      scnd_r     <= 1'b0;
      st_r       <= ST_INSERTED;
      ov_r       <= 1'b0;
      after_p_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      srch_end_r <= srch_end_nxt;
      ins_end_r  <= ins_end_nxt;
      scnd_r     <= scnd_nxt;
      st_r       <= st_nxt;
      ov_r       <= ov_nxt;
      after_p_r  <= after_p_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE) || ov_r;
  assign out_valid = ov_r;

endmodule

FILE: sv/sorted_interval_timeline.sv
// Sorted interval timeline.
// Input channel: in_valid/in_stall carry one interval request (command id,
// start time, end time). Output channel: out_valid/out_stall carry one result
// (status, entry count) per request.
// Each request is worked on alone. The work is bounded by the single read
// port of the entry memories: up to three binary searches run per request,
// each inserted entry shifts the entries above it one by one with a read and
// a write per entry, and marking reads and writes each entry in the range.
// An order error goes from the check state straight to the result state.
// The result is held in an output register; a new request is taken in the
// cycle after that result has been taken, so a stalled receiver holds the
// input stalled too. Reset empties the table at once; entry memories are not
// cleared since only entries below the count are read.
module sorted_interval_timeline #(
  parameter int MAX_ENTRIES  = 256,
  parameter int MAX_COMMANDS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [5:0]         in_command_id,
  input  logic signed [31:0] in_start_time,
  input  logic signed [31:0] in_end_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [8:0]         out_entry_count
);
  import sit_pkg::*;

  sit_cmd_t   cmd;
  sit_stat_t  stat;
  logic       res_load;
  logic [1:0] res_status;
  logic [8:0] res_count;
  logic [1:0] status_r;
  logic [8:0] count_r;

  sit_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd),
    .res_load(res_load));

  sit_datapath #(.MaxEntries(MAX_ENTRIES), .MaxCommands(MAX_COMMANDS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_command_id(in_command_id), .in_start_time(in_start_time),
    .in_end_time(in_end_time), .res_status(res_status),
    .res_entry_count(res_count));

  // Output register; the count is already final when the result is loaded.
  always_ff @(posedge clk) begin
    if (res_load) begin
      status_r <= res_status;
      count_r  <= res_count;
    end
  end

  assign out_status      = status_r;
  assign out_entry_count = count_r;

endmodule

FILE: sv/sit_checker.sv
`include "sorted_interval_timeline_macros.svh"
module sit_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_status,
  input logic [8:0] out_entry_count
);
  import sit_pkg::*;

  // A result is never shown with a status outside the three codes.
  `SIT_ASSERT_IMP(a_status_code, clk, rst_n, out_valid,
    out_status == ST_INSERTED || out_status == ST_FULL || out_status == ST_ORDER)
  // A stalled result stays in place.
  `SIT_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_entry_count) && $stable(out_status))
  // No request is taken while a result waits.
  `SIT_ASSERT_IMP(a_one_open, clk, rst_n, out_valid, in_stall)
  // A taken request produces no result in the next cycle.
  `SIT_ASSERT_NEXT(a_no_instant, clk, rst_n, in_valid && !in_stall, !out_valid)

endmodule

bind sorted_interval_timeline sit_checker u_sit_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_entry_count(out_entry_count));

FILE: bench/sorted_interval_timeline_tb.sv
module sorted_interval_timeline_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sit_pkg::*;

  localparam int TABLE_DEPTH = 256;
  localparam int RANDOM_REQUESTS = 1000;
  localparam int DIRECTED_ROWS = 10;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [5:0]         in_command_id;
  logic signed [31:0] in_start_time;
  logic signed [31:0] in_end_time;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_status;
  logic [8:0]         out_entry_count;

  sorted_interval_timeline u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command_id(in_command_id), .in_start_time(in_start_time),
    .in_end_time(in_end_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_entry_count(out_entry_count)
  );

  typedef struct {
    logic [1:0] status;
    logic [8:0] count;
  } timeline_result_t;

  typedef struct {
    logic [5:0]         cid;
    logic signed [31:0] t_start;
    logic signed [31:0] t_end;
    bit                 typed;  // expected result given in the table
    logic [1:0]         status;
    logic [8:0]         count;
  } request_row_t;

  // Shadow copy of the timeline.
  logic signed [31:0] shadow_time [TABLE_DEPTH];
  logic [63:0]        shadow_mask [TABLE_DEPTH];
  int                 shadow_used;

  request_row_t     directed_rows [DIRECTED_ROWS];
  timeline_result_t pending_results[$];
  int               mismatch_count;
  bit               stimulus_done;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Appends one expectation to the queue of outstanding results.
  function automatic void expect_result(input timeline_result_t r);
    pending_results = {pending_results, r};
  endfunction

  // Binary search over [lo, shadow_used); gives the match or insertion point.
  function automatic bit search_time(input int lo, input logic signed [31:0] t,
                                     output int pos);
    int hi;
    int mid;
    hi = shadow_used;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (shadow_time[mid] == t) begin
        pos = mid;
        return 1'b1;
      end
      if (shadow_time[mid] > t) hi = mid;
      else lo = mid + 1;
    end
    pos = lo;
    return 1'b0;
  endfunction

  // A new entry takes the AND of its neighbours, or an empty mask at the ends.
  function automatic void add_entry(input int pos, input logic signed [31:0] t);
    logic [63:0] m;
    m = '0;
    if (pos != 0 && pos < shadow_used) m = shadow_mask[pos-1] & shadow_mask[pos];
    for (int i = shadow_used; i > pos; i--) begin
      shadow_time[i] = shadow_time[i-1];
      shadow_mask[i] = shadow_mask[i-1];
    end
    shadow_time[pos] = t;
    shadow_mask[pos] = m;
    shadow_used++;
  endfunction

  // Applies one interval request to the shadow timeline.
  function automatic timeline_result_t apply_interval(
      input logic [5:0] cid, input logic signed [31:0] s,
      input logic signed [31:0] e);
    timeline_result_t r;
    logic [63:0] bitm;
    int p;
    int q;
    int need;
    bit sf;
    bit ef;
    bitm = 64'd1 << cid;
    r.status = ST_INSERTED;
    if (e < s) begin
      r.status = ST_ORDER;
    end else if (shadow_used == 0) begin
      shadow_time[0] = s;
      shadow_mask[0] = bitm;
      shadow_used = 1;
      if (s != e) begin
        shadow_time[1] = e;
        shadow_mask[1] = bitm;
        shadow_used = 2;
      end
    end else begin
      sf = search_time(0, s, p);
      ef = search_time(0, e, q);
      need = 0;
      if (!sf) need++;
      if (s != e && !ef) need++;
      if (shadow_used + need > TABLE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        if (!sf) add_entry(p, s);
        if (s == e) q = p;
        else if (!search_time(p, e, q)) add_entry(q, e);
        for (int i = p; i <= q && i < shadow_used; i++) shadow_mask[i] |= bitm;
      end
    end
    r.count = shadow_used[8:0];
    return r;
  endfunction

  // Offers one request and waits until it is accepted; valid stays high
  // into the next request when no gap follows.
  task automatic send_request(input logic [5:0] cid, input logic signed [31:0] s,
                              input logic signed [31:0] e);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command_id <= cid;
    in_start_time <= s;
    in_end_time   <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Random timestamps: mostly from a narrow band so that boundaries coincide.
  function automatic logic signed [31:0] pick_time(input int band);
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom;
      default: return $signed($urandom_range(0, band)) - band / 2;
    endcase
  endfunction

  function automatic logic [5:0] u_pick_cid(input int n);
    return 6'(n * 37 + 11);
  endfunction

  // Directed table, then random requests.
  initial begin
    request_row_t row;
    timeline_result_t exp_r;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic [5:0] cid;
    int band;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command_id = '0;
    in_start_time = '0;
    in_end_time = '0;
    shadow_used = 0;
    stimulus_done = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    directed_rows = '{
      '{6'd5, 32'sd10, 32'sd9, 1'b1, ST_ORDER, 9'd0},
      '{6'd0, 32'sd100, 32'sd100, 1'b1, ST_INSERTED, 9'd1},
      '{6'd63, 32'sh80000000, 32'sh7fffffff, 1'b1, ST_INSERTED, 9'd3},
      '{6'd1, 32'sd50, 32'sd200, 1'b0, ST_INSERTED, 9'd0},
      '{6'd2, 32'sd60, 32'sd60, 1'b0, ST_INSERTED, 9'd0},
      '{6'd3, 32'sd100, 32'sd150, 1'b0, ST_INSERTED, 9'd0},
      '{6'd42, 32'sh7fffffff, 32'sh80000000, 1'b0, ST_INSERTED, 9'd0},
      '{6'd21, -32'sd1, 32'sd0, 1'b0, ST_INSERTED, 9'd0},
      '{6'd4, 32'sh80000000, 32'sd50, 1'b0, ST_INSERTED, 9'd0},
      '{6'd7, 32'sd55, 32'sd250, 1'b0, ST_INSERTED, 9'd0}
    };
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      exp_r = apply_interval(row.cid, row.t_start, row.t_end);
      if (row.typed) begin
        exp_r.status = row.status;
        exp_r.count  = row.count;
      end
      expect_result(exp_r);
      send_request(row.cid, row.t_start, row.t_end);
    end

    // Narrow bands (64) alternate with wide bands (2000) that fill the table.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      band = (n % 250 < 150) ? 64 : 2000;
      a = pick_time(band);
      b = ($urandom_range(0, 4) == 0) ? a : pick_time(band);
      if ($urandom_range(0, 15) != 0 && b < a) begin
        a = a ^ b; b = a ^ b; a = a ^ b;
      end
      cid = u_pick_cid(n);
      exp_r = apply_interval(cid, a, b);
      expect_result(exp_r);
      send_request(cid, a, b);
    end
    in_valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Receiver stall: random gaps, with one long hold-off early in the run.
  initial begin
    int gap;
    out_stall = 1'b0;
    @(posedge rst_n);
    repeat (300) @(posedge clk);
    out_stall <= 1'b1;
    repeat (3000) @(posedge clk);
    forever begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) gap = 0;
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    timeline_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result status=%0d count=%0d",
                                           out_status, out_entry_count);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_status !== exp_r.status || out_entry_count !== exp_r.count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected status=%0d count=%0d, got status=%0d count=%0d",
                     exp_r.status, exp_r.count, out_status, out_entry_count);
        end
      end
    end
  end

  // End of run once every expected result has arrived.
  initial begin
    wait (stimulus_done);
    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #200ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/sit_pkg.sv
sv/sit_ram.sv
sv/sit_datapath.sv
sv/sit_ctrl.sv
sv/sorted_interval_timeline.sv
sv/sit_checker.sv
bench/sorted_interval_timeline_tb.sv
